@@ src/sat_pkg.sv @@
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, codes and helpers of the section address translator.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int DEFAULT_MAX_SECTIONS = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILE_ALIGN   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECT_ALIGN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_SLOTS = 2'd2;

   localparam logic [CSR_DATA_W-1:0] RESET_FILE_ALIGN   = 5'd9;
   localparam logic [CSR_DATA_W-1:0] RESET_SECT_ALIGN   = 5'd12;
   localparam logic [CSR_DATA_W-1:0] RESET_HEADER_SLOTS = 5'd16;

   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 160;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_V2F    = 2'd1,
      FUNC_F2V    = 2'd2,
      FUNC_APPEND = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_NO_ROOM   = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   // One section table entry as stored in the RAM.
   typedef struct packed {
      logic [31:0] rawsize;
      logic [31:0] rawptr;
      logic [31:0] vsize;
      logic [31:0] vaddr;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       scan_inc;
      logic       rd_last;
      logic       check_en;
      logic       sum_en;
      logic       align_en;
      logic       total_en;
      logic       commit;
      status_type status;
   } sat_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type req_func;
      logic     count_zero;
      logic     count_full;
      logic     no_header_room;
      logic     scan_last;
      logic     hit;
      logic     out_free;
   } sat_sts_type;

   // Round v up to a multiple of 2**log2a, modulo 2**32.
   function automatic logic [31:0] round_up(input logic [31:0] v, input logic [4:0] log2a);
      logic [31:0] m;
      m = (32'd1 << log2a) - 32'd1;
      return (v + m) & ~m;
   endfunction

endpackage

@@ src/sat_ram.sv @@
// ----------------------------------------------------------------------------
// sat_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/sat_ctrl.sv @@
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer for load, translation scan and append of the section table.
// ----------------------------------------------------------------------------
module sat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sat_pkg::sat_sts_type sts,
   output sat_pkg::sat_cmd_type cmd
);

   import sat_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_FETCH     = 8'b0000_0010,
      S_CHECK     = 8'b0000_0100,
      S_APP_READ  = 8'b0000_1000,
      S_APP_SUM   = 8'b0001_0000,
      S_APP_ALIGN = 8'b0010_0000,
      S_APP_TOTAL = 8'b0100_0000,
      S_FINISH    = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   status_type stat_ff, stat_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      stat_in      = stat_ff;
      cmd          = '0;
      cmd.capture  = accept;
      cmd.status   = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (sts.req_func) inside
                  FUNC_LOAD: begin
                     stat_in  = sts.count_full ? ST_NO_ROOM : ST_OK;
                     state_in = S_FINISH;
                  end
                  FUNC_V2F, FUNC_F2V: begin
                     if (sts.count_zero) begin
                        stat_in  = ST_NOT_FOUND;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  FUNC_APPEND: begin
                     if (sts.count_zero) begin
                        stat_in  = ST_EMPTY;
                        state_in = S_FINISH;
                     end else if (sts.no_header_room) begin
                        stat_in  = ST_NO_ROOM;
                        state_in = S_FINISH;
                     end else begin
                        stat_in  = ST_OK;
                        state_in = S_APP_READ;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check_en = 1'b1;
            if (sts.hit) begin
               stat_in  = ST_OK;
               state_in = S_FINISH;
            end else if (sts.scan_last) begin
               stat_in  = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in     = S_FETCH;
            end
         end
         S_APP_READ: begin
            cmd.rd_last = 1'b1;
            state_in    = S_APP_SUM;
         end
         S_APP_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_APP_ALIGN;
         end
         S_APP_ALIGN: begin
            cmd.align_en = 1'b1;
            state_in     = S_APP_TOTAL;
         end
         S_APP_TOTAL: begin
            cmd.total_en = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stat_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         stat_ff  <= stat_in;
      end
   end

endmodule

@@ src/sat_datapath.sv @@
// ----------------------------------------------------------------------------
// sat_datapath
// Section table storage, configuration registers, range check, alignment
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module sat_datapath #(
   parameter int MAX_SECTIONS = sat_pkg::DEFAULT_MAX_SECTIONS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sat_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sat_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                         rsp_tuser,
   input  logic                               csr_valid,
   input  logic [sat_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]     csr_data,
   input  sat_pkg::sat_cmd_type               cmd,
   output sat_pkg::sat_sts_type               sts
);

   import sat_pkg::*;

   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
   localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

   // Configuration registers.
   logic [CSR_DATA_W-1:0] fa_ff, fa_in, sa_ff, sa_in, hs_ff, hs_in;

   // Control registers.
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   func_type                func_ff, func_in;
   entry_type               entry_ff, entry_in;
   logic [31:0]             addr_ff, addr_in, asize_ff, asize_in;
   logic [31:0]             diff_ff, diff_in, tobase_ff, tobase_in;
   logic [31:0]             raw_end_ff, raw_end_in, virt_end_ff, virt_end_in;
   logic [31:0]             nrs_ff, nrs_in, asec_ff, asec_in;
   logic [31:0]             nro_ff, nro_in, nva_ff, nva_in, tot_ff, tot_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // RAM and combinational helpers.
   entry_type        rd_entry, wr_entry;
   logic             ram_we;
   logic [IDX_W-1:0] raddr;
   logic [CNT_W-1:0] last_idx;
   logic [31:0]      from_base, from_size, to_base, from_end;
   logic             is_v2f, is_xlat, is_app, ok;

   sat_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_SECTIONS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (wr_entry),
      .raddr (raddr),
      .rdata (rd_entry)
   );

   assign last_idx = count_ff - CNT_W'(1);
   assign raddr    = cmd.rd_last ? last_idx[IDX_W-1:0] : scan_ff;

   // Range check of the entry under scan.
   assign is_v2f    = (func_ff == FUNC_V2F);
   assign from_base = is_v2f ? rd_entry.vaddr  : rd_entry.rawptr;
   assign from_size = is_v2f ? rd_entry.vsize  : rd_entry.rawsize;
   assign to_base   = is_v2f ? rd_entry.rawptr : rd_entry.vaddr;
   assign from_end  = from_base + from_size;

   assign is_xlat = (func_ff == FUNC_V2F) || (func_ff == FUNC_F2V);
   assign is_app  = (func_ff == FUNC_APPEND);
   assign ok      = (cmd.status == ST_OK);

   assign ram_we = cmd.commit && ok && ((func_ff == FUNC_LOAD) || is_app);

   always_comb begin
      wr_entry = entry_ff;
      if (is_app) begin
         wr_entry.vaddr   = nva_ff;
         wr_entry.vsize   = asize_ff;
         wr_entry.rawptr  = nro_ff;
         wr_entry.rawsize = nrs_ff;
      end
   end

   always_comb begin
      sts.req_func       = func_type'(req_tuser);
      sts.count_zero     = (count_ff == '0);
      sts.count_full     = (count_ff == CNT_W'(MAX_SECTIONS));
      sts.no_header_room = sts.count_full || (32'(count_ff) >= 32'(hs_ff));
      sts.scan_last      = (CNT_W'(scan_ff) == last_idx);
      sts.hit            = (addr_ff >= from_base) && (addr_ff < from_end);
      sts.out_free       = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      fa_in = fa_ff;
      sa_in = sa_ff;
      hs_in = hs_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILE_ALIGN:   fa_in = csr_data;
            CSR_SECT_ALIGN:   sa_in = csr_data;
            CSR_HEADER_SLOTS: hs_in = csr_data;
            default:          ;
         endcase
      end
   end

   always_comb begin
      count_in      = count_ff;
      scan_in       = scan_ff;
      rsp_valid_in  = rsp_valid_ff;
      func_in       = func_ff;
      entry_in      = entry_ff;
      addr_in       = addr_ff;
      asize_in      = asize_ff;
      diff_in       = diff_ff;
      tobase_in     = tobase_ff;
      raw_end_in    = raw_end_ff;
      virt_end_in   = virt_end_ff;
      nrs_in        = nrs_ff;
      asec_in       = asec_ff;
      nro_in        = nro_ff;
      nva_in        = nva_ff;
      tot_in        = tot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         func_in          = func_type'(req_tuser);
         entry_in.vaddr   = req_tdata[31:0];
         entry_in.vsize   = req_tdata[63:32];
         entry_in.rawptr  = req_tdata[95:64];
         entry_in.rawsize = req_tdata[127:96];
         addr_in          = req_tdata[159:128];
         asize_in         = req_tdata[191:160];
         scan_in          = '0;
      end
      if (cmd.scan_inc) begin
         scan_in = scan_ff + IDX_W'(1);
      end
      if (cmd.check_en) begin
         diff_in   = addr_ff - from_base;
         tobase_in = to_base;
      end
      if (cmd.sum_en) begin
         raw_end_in  = rd_entry.rawptr + rd_entry.rawsize;
         virt_end_in = rd_entry.vaddr + rd_entry.vsize;
         nrs_in      = round_up(asize_ff, fa_ff);
         asec_in     = round_up(asize_ff, sa_ff);
      end
      if (cmd.align_en) begin
         nro_in = round_up(raw_end_ff, fa_ff);
         nva_in = round_up(virt_end_ff, sa_ff);
      end
      if (cmd.total_en) begin
         tot_in = nva_ff + asec_ff;
      end

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         rsp_data_in   = '0;
         if (ok && is_xlat) begin
            rsp_data_in[31:0] = diff_ff + tobase_ff;
         end
         if (ok && is_app) begin
            rsp_data_in[63:32]   = nva_ff;
            rsp_data_in[95:64]   = nro_ff;
            rsp_data_in[127:96]  = nrs_ff;
            rsp_data_in[159:128] = round_up(tot_ff, sa_ff);
         end
      end
      if (ram_we) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff        <= RESET_FILE_ALIGN;
         sa_ff        <= RESET_SECT_ALIGN;
         hs_ff        <= RESET_HEADER_SLOTS;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fa_ff        <= fa_in;
         sa_ff        <= sa_in;
         hs_ff        <= hs_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      func_ff       <= func_in;
      entry_ff      <= entry_in;
      addr_ff       <= addr_in;
      asize_ff      <= asize_in;
      diff_ff       <= diff_in;
      tobase_ff     <= tobase_in;
      raw_end_ff    <= raw_end_in;
      virt_end_ff   <= virt_end_in;
      nrs_ff        <= nrs_in;
      asec_ff       <= asec_in;
      nro_ff        <= nro_in;
      nva_ff        <= nva_in;
      tot_ff        <= tot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ src/section_address_translator.sv @@
// ----------------------------------------------------------------------------
// section_address_translator
// Executable-image section table with address translation and section append.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------
//  req_    | in        | req_tvalid/req_tready  | tuser: func; tdata: entry,
//          |           |                        | lookup address, append size
//  rsp_    | out       | rsp_tvalid/rsp_tready  | tuser: status; tdata: results
//  csr_    | in        | csr_valid/csr_ready    | csr_index, csr_data
//
// A load or any early failure goes from accept straight to the result. A
// translation scans the entries in order until a hit or the last entry:
// the table RAM has one read port with registered data, so each entry costs
// a read step and a range-check step. An append is a read of the last entry
// followed by a four-step alignment chain.
// Reset is synchronous and active high; it empties the table and loads the
// default alignments and header slot count. Table contents are not cleared.
// A new word is accepted while the previous result waits on rsp_; a result
// that cannot leave holds the block in its final step until rsp_tready.
// The configuration port is always ready.
//
module section_address_translator #(
   parameter int MAX_SECTIONS = sat_pkg::DEFAULT_MAX_SECTIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request word.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // From bit 0: entry_virtual_address[31:0], entry_virtual_size[31:0],
   // entry_raw_pointer[31:0], entry_raw_size[31:0], lookup_address[31:0],
   // append_size[31:0].
   input  logic [sat_pkg::REQ_DATA_W-1:0]  req_tdata,
   // From bit 0: func[1:0].
   input  logic [1:0]                      req_tuser,
   // Response word.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // From bit 0: translated_address[31:0], new_virtual_address[31:0],
   // new_raw_offset[31:0], new_raw_size[31:0], image_size[31:0].
   output logic [sat_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // From bit 0: status[1:0].
   output logic [1:0]                      rsp_tuser,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sat_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sat_pkg::CSR_DATA_W-1:0]  csr_data
);

   import sat_pkg::*;

   sat_cmd_type cmd;
   sat_sts_type sts;

   assign csr_ready = 1'b1;

   // The controller sequences each word; the datapath holds the table, the
   // configuration and the result register.
   sat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   sat_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

`ifndef ASSERT_OFF
   // Every accepted word takes the block out of its ready state.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a word was still in progress");

   // A result is never written over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten before it was taken");

   // A failed word carries no append results.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != ST_OK)) |-> (rsp_tdata[159:32] == '0))
      else $error("failed word carries nonzero append fields");
`endif

endmodule

@@ tb/section_address_translator_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// section_address_translator_test
// Self-checking bench for the section table and its address translations.
// Requests go in through a queue-fed driver with random idle cycles. A shadow
// section table inside the bench works out the expected response of each
// accepted request word. A monitor compares every response word, field by
// field, with the oldest expected response.
// ----------------------------------------------------------------------------
module section_address_translator_test;

   import sat_pkg::*;

   localparam int TABLE_DEPTH    = DEFAULT_MAX_SECTIONS;
   localparam int ITEM_TARGET    = 1150;
   localparam int IDLE_PERCENT   = 13;
   localparam int QUIET_LIMIT    = 2000;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_AFTER     = 300;
   localparam int SETTLE_CYCLES  = 40;
   localparam int REPORT_LIMIT   = 10;

   // Request payload, declared from the top bit down so that it lines up with
   // req_tdata (entry_virtual_address sits in bits 31:0).
   typedef struct packed {
      logic [31:0] append_size;
      logic [31:0] lookup_address;
      logic [31:0] entry_raw_size;
      logic [31:0] entry_raw_pointer;
      logic [31:0] entry_virtual_size;
      logic [31:0] entry_virtual_address;
   } request_payload_type;

   typedef struct packed {
      func_type            func;
      request_payload_type payload;
   } request_type;

   // Response payload, laid out like rsp_tdata (translated_address in 31:0).
   typedef struct packed {
      logic [31:0] image_size;
      logic [31:0] new_raw_size;
      logic [31:0] new_raw_offset;
      logic [31:0] new_virtual_address;
      logic [31:0] translated_address;
   } result_payload_type;

   typedef struct packed {
      status_type         status;
      result_payload_type payload;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // From bit 0: entry_virtual_address, entry_virtual_size, entry_raw_pointer,
   // entry_raw_size, lookup_address, append_size (32 bits each).
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // From bit 0: func.
   logic [1:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // From bit 0: translated_address, new_virtual_address, new_raw_offset,
   // new_raw_size, image_size (32 bits each).
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // From bit 0: status.
   logic [1:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // Shadow copy of the block's section table and its registers.
   logic [31:0] image_vaddr   [TABLE_DEPTH];
   logic [31:0] image_vsize   [TABLE_DEPTH];
   logic [31:0] image_rawptr  [TABLE_DEPTH];
   logic [31:0] image_rawsize [TABLE_DEPTH];
   int          image_sections = 0;
   logic [4:0]  file_align_lg    = RESET_FILE_ALIGN;
   logic [4:0]  section_align_lg = RESET_SECT_ALIGN;
   logic [4:0]  header_room      = RESET_HEADER_SLOTS;

   request_type  request_backlog[$];
   response_type awaited_responses[$];
   request_type  offered;

   int  queued_count   = 0;
   int  accepted_count = 0;
   int  fault_count    = 0;
   int  quiet_cycles   = 0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;
   // While set, neither side idles.
   bit  steady         = 1'b0;

   always #4 clock = ~clock;

   section_address_translator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Shadow table
   // -------------------------------------------------------------------------

   // Rounds a value up to a multiple of 2**lg; the sum wraps at 32 bits.
   function automatic logic [31:0] align_up(input logic [31:0] value, input logic [4:0] lg);
      logic [31:0] low_bits;
      low_bits = ~(32'hFFFF_FFFF << lg);
      return (value + low_bits) & ~low_bits;
   endfunction

   // Applies one request word to the shadow table and returns the response
   // the block owes for it.
   function automatic response_type apply_operation(input request_type rq);
      response_type rs;
      logic [31:0]  from_base;
      logic [31:0]  from_span;
      logic [31:0]  from_end;
      logic [31:0]  to_base;
      logic [31:0]  raw_end;
      logic [31:0]  virt_end;
      int           last;
      rs = '0;
      rs.status = ST_OK;
      case (rq.func)
         FUNC_LOAD: begin
            if (image_sections >= TABLE_DEPTH) begin
               rs.status = ST_NO_ROOM;
            end else begin
               image_vaddr[image_sections]   = rq.payload.entry_virtual_address;
               image_vsize[image_sections]   = rq.payload.entry_virtual_size;
               image_rawptr[image_sections]  = rq.payload.entry_raw_pointer;
               image_rawsize[image_sections] = rq.payload.entry_raw_size;
               image_sections++;
            end
         end
         FUNC_V2F, FUNC_F2V: begin
            // The first section whose half-open range holds the address wins.
            // A range whose end wraps to or below its start holds nothing.
            rs.status = ST_NOT_FOUND;
            for (int n = 0; n < image_sections; n++) begin
               from_base = (rq.func == FUNC_V2F) ? image_vaddr[n] : image_rawptr[n];
               from_span = (rq.func == FUNC_V2F) ? image_vsize[n] : image_rawsize[n];
               to_base   = (rq.func == FUNC_V2F) ? image_rawptr[n] : image_vaddr[n];
               from_end  = from_base + from_span;
               if (rs.status == ST_NOT_FOUND && rq.payload.lookup_address >= from_base &&
                   rq.payload.lookup_address < from_end) begin
                  rs.status = ST_OK;
                  rs.payload.translated_address = rq.payload.lookup_address - from_base + to_base;
               end
            end
         end
         default: begin
            if (image_sections == 0) begin
               rs.status = ST_EMPTY;
            end else if (image_sections >= int'(header_room) || image_sections >= TABLE_DEPTH) begin
               rs.status = ST_NO_ROOM;
            end else begin
               // The new section goes right after the last one, both in the
               // file and in memory, each rounded to its own alignment.
               last     = image_sections - 1;
               raw_end  = image_rawptr[last] + image_rawsize[last];
               virt_end = image_vaddr[last] + image_vsize[last];
               rs.payload.new_raw_offset      = align_up(raw_end, file_align_lg);
               rs.payload.new_raw_size        = align_up(rq.payload.append_size, file_align_lg);
               rs.payload.new_virtual_address = align_up(virt_end, section_align_lg);
               rs.payload.image_size = align_up(rs.payload.new_virtual_address +
                  align_up(rq.payload.append_size, section_align_lg), section_align_lg);
               image_vaddr[image_sections]   = rs.payload.new_virtual_address;
               image_vsize[image_sections]   = rq.payload.append_size;
               image_rawptr[image_sections]  = rs.payload.new_raw_offset;
               image_rawsize[image_sections] = rs.payload.new_raw_size;
               image_sections++;
            end
         end
      endcase
      return rs;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Fields that the operation does not use carry random values.
   task automatic offer(input func_type func, input logic [31:0] va, input logic [31:0] vs,
                        input logic [31:0] rp, input logic [31:0] rz,
                        input logic [31:0] address, input logic [31:0] span);
      request_type rq;
      rq.func = func;
      rq.payload.entry_virtual_address = va;
      rq.payload.entry_virtual_size    = vs;
      rq.payload.entry_raw_pointer     = rp;
      rq.payload.entry_raw_size        = rz;
      rq.payload.lookup_address        = address;
      rq.payload.append_size           = span;
      request_backlog.push_back(rq);
      queued_count++;
   endtask

   task automatic offer_load(input logic [31:0] va, input logic [31:0] vs,
                             input logic [31:0] rp, input logic [31:0] rz);
      offer(FUNC_LOAD, va, vs, rp, rz, $urandom, $urandom);
   endtask

   task automatic offer_lookup(input func_type func, input logic [31:0] address);
      offer(func, $urandom, $urandom, $urandom, $urandom, address, $urandom);
   endtask

   task automatic offer_append(input logic [31:0] span);
      offer(FUNC_APPEND, $urandom, $urandom, $urandom, $urandom, $urandom, span);
   endtask

   // Sizes lean small so that ranges rarely wrap, with the extremes mixed in.
   function automatic logic [31:0] random_span();
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return 32'h0;
         2: return 32'hFFFF_FFFF;
         3: return $urandom_range(0, 255);
         default: return $urandom_range(0, 32'h0010_0000);
      endcase
   endfunction

   function automatic logic [4:0] random_alignment();
      case ($urandom_range(0, 3))
         0: return 5'd0;
         1: return 5'd31;
         default: return 5'($urandom_range(0, 31));
      endcase
   endfunction

   // Aims mostly at the edges and the inside of a known section, so that the
   // scan reaches entries deep in the table; the rest is noise.
   function automatic logic [31:0] lookup_target(input func_type func);
      logic [31:0] base;
      logic [31:0] span;
      int          n;
      if (image_sections == 0 || $urandom_range(0, 9) < 2) begin
         return $urandom;
      end
      n    = $urandom_range(0, image_sections - 1);
      base = (func == FUNC_V2F) ? image_vaddr[n] : image_rawptr[n];
      span = (func == FUNC_V2F) ? image_vsize[n] : image_rawsize[n];
      case ($urandom_range(0, 5))
         0: return base;
         1: return base + span - 32'd1;
         2: return base + span;
         3: return base - 32'd1;
         default: return (span == 0) ? base : base + ($urandom % span);
      endcase
   endfunction

   task automatic queue_random(input int count, input int lookup_pct, input int append_pct);
      int       pick;
      func_type func;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < lookup_pct) begin
            func = $urandom_range(0, 1) ? FUNC_V2F : FUNC_F2V;
            offer_lookup(func, lookup_target(func));
         end else if (pick < lookup_pct + append_pct) begin
            offer_append(random_span());
         end else begin
            offer_load($urandom, random_span(), $urandom, random_span());
         end
      end
   endtask

   // One register write; the shadow copy follows once the write is taken.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FILE_ALIGN:   file_align_lg    = value;
         CSR_SECT_ALIGN:   section_align_lg = value;
         CSR_HEADER_SLOTS: header_room      = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [4:0] file_lg, input logic [4:0] sect_lg,
                            input logic [4:0] slots);
      write_register(CSR_FILE_ALIGN, file_lg);
      write_register(CSR_SECT_ALIGN, sect_lg);
      write_register(CSR_HEADER_SLOTS, slots);
   endtask

   // Every request makes exactly one response, so once all queued words are
   // taken and all responses are back, the block is idle.
   task automatic drain();
      do @(posedge clock);
      while (accepted_count != queued_count || awaited_responses.size() != 0);
   endtask

   task automatic record_fault(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("mismatch on %s: expected 0x%08h, got 0x%08h", what, want, got);
      end
   endtask

   task automatic record_fault_if(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (got !== want) begin
         record_fault(what, want, got);
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset alignments (file 2**9, section 2**12, 16 header slots).
      // An empty table: both translations miss and an append is refused.
      offer_lookup(FUNC_V2F, 32'h0000_0000);
      offer_lookup(FUNC_F2V, 32'hFFFF_FFFF);
      offer_append(32'h0000_0100);
      // A plain section, probed at its first byte, its last byte, one past
      // the end and one below the start.
      offer_load(32'h0000_1000, 32'h0000_0800, 32'h0000_0400, 32'h0000_0600);
      offer_lookup(FUNC_V2F, 32'h0000_1000);
      offer_lookup(FUNC_V2F, 32'h0000_17FF);
      offer_lookup(FUNC_V2F, 32'h0000_1800);
      offer_lookup(FUNC_V2F, 32'h0000_0FFF);
      offer_lookup(FUNC_F2V, 32'h0000_09FF);
      // Sections whose ranges wrap past the top of the address space match
      // nothing at all.
      offer_load(32'hFFFF_F000, 32'h0000_2000, 32'hFFFF_FFFF, 32'h0000_0001);
      offer_lookup(FUNC_V2F, 32'hFFFF_F800);
      offer_lookup(FUNC_F2V, 32'hFFFF_FFFF);
      // An empty section is never hit.
      offer_load(32'h0000_3000, 32'h0000_0000, 32'h0000_2000, 32'h0000_0000);
      offer_lookup(FUNC_V2F, 32'h0000_3000);
      // Overlap with the first section: the earlier entry wins.
      offer_load(32'h0000_1400, 32'h0000_1000, 32'h0000_8000, 32'h0000_1000);
      offer_lookup(FUNC_V2F, 32'h0000_1500);
      offer_lookup(FUNC_V2F, 32'h0000_2000);
      // A section that reaches the last address; its end is exclusive.
      offer_load(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      offer_lookup(FUNC_V2F, 32'hFFFF_FFFE);
      // Appends whose rounded placement wraps around zero.
      offer_append(32'h0000_0000);
      offer_append(32'hFFFF_FFFF);
      offer_lookup(FUNC_F2V, 32'h0000_0000);
      offer_lookup(FUNC_V2F, 32'hFFFF_FFFF);
      drain();

      // Byte alignment, then the widest alignment.
      configure(5'd0, 5'd0, 5'd16);
      offer_append(32'h0000_0123);
      offer_append(random_span());
      queue_random(6, 100, 0);
      drain();
      configure(5'd31, 5'd31, 5'd16);
      offer_append(32'h1234_5678);
      offer_append(32'h8000_0001);
      queue_random(6, 100, 0);
      drain();

      // Header room: none at all, exactly used up, then one slot left.
      configure(random_alignment(), random_alignment(), 5'd0);
      offer_append($urandom);
      queue_random(4, 100, 0);
      drain();
      configure(RESET_FILE_ALIGN, RESET_SECT_ALIGN, 5'(image_sections));
      offer_append(random_span());
      drain();
      configure(random_alignment(), random_alignment(), 5'(image_sections + 1));
      offer_append(random_span());
      offer_append(random_span());
      drain();

      // Grow the table to its full depth under changing settings.
      while (image_sections < TABLE_DEPTH) begin
         configure(random_alignment(), random_alignment(),
                   $urandom_range(0, 1) ? 5'd16 : 5'($urandom_range(0, 16)));
         queue_random(30, 50, 30);
         drain();
      end

      // A full table refuses both a load and an append, even with the header
      // slot count set to the table depth.
      configure(random_alignment(), random_alignment(), 5'd16);
      offer_load($urandom, random_span(), $urandom, random_span());
      offer_append(random_span());
      drain();

      // Mostly translations against the full table; one phase runs with no
      // idle cycles on either side.
      for (int phase = 0; queued_count < ITEM_TARGET; phase++) begin
         configure(random_alignment(), random_alignment(), 5'($urandom_range(0, 16)));
         steady = (phase == 3);
         queue_random(100, 88, 8);
         drain();
      end
      steady = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         record_fault("responses still owed", 32'd0, 32'(awaited_responses.size()));
      end
      if (fault_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request driver: takes the next word from the backlog whenever the current
   // one has been taken or none is offered, and idles now and then.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_responses.push_back(apply_operation(offered));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (request_backlog.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               offered = request_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= offered.payload;
               req_tuser  <= offered.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: checks each response word against the oldest expected
   // one. Once, after a few hundred requests, it stops taking responses for a
   // long stretch so that the block backs up and stalls its request side.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_responses.size() == 0) begin
               record_fault("unexpected response, translated_address", 32'd0,
                            rsp_tdata[31:0]);
            end else begin
               want = awaited_responses.pop_front();
               record_fault_if("status", 32'(want.status), 32'(rsp_tuser));
               record_fault_if("translated_address",
                               want.payload.translated_address, rsp_tdata[31:0]);
               record_fault_if("new_virtual_address",
                               want.payload.new_virtual_address, rsp_tdata[63:32]);
               record_fault_if("new_raw_offset",
                               want.payload.new_raw_offset, rsp_tdata[95:64]);
               record_fault_if("new_raw_size",
                               want.payload.new_raw_size, rsp_tdata[127:96]);
               record_fault_if("image_size",
                               want.payload.image_size, rsp_tdata[159:128]);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a run in which no word moves on any channel for too long has
   // hung.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
